/* hw/rtl/mhpq_pkg.sv */
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and codes for the max-heap priority queue: result status,
// opcodes, register map, sequencer states and the token handed between cells.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } mhpq_status_t;

  localparam logic ACT_INSERT  = 1'b0;
  localparam logic ACT_EXTRACT = 1'b1;

  // register map: index = paddr[2]
  localparam int          APB_ADDR_BITS = 3;
  localparam int          APB_DATA_BITS = 32;
  localparam logic        REG_CAPACITY  = 1'b0;
  localparam int          CAP_BITS      = 7;
  localparam logic [6:0]  CAP_RESET     = 7'd64;
  localparam int          FILL_BITS     = 7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_BUSY,
    ST_DONE
  } mhpq_state_t;

  // control part of the word walking down the chain of level cells
  typedef struct packed {
    logic active;
    logic extract;
    logic shifting;
  } mhpq_tok_t;

endpackage

/* hw/rtl/max_heap_priority_queue.sv */
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Flow: a refused insert or an empty extract goes from IDLE straight to DONE;
//   an extract of the only entry passes through FETCH; an insert walks the chain
//   down to the level it lands on, an extract until its sift-down ends.
// Throughput: one word at a time, next word taken the cycle after the result
//   registers; each heap level costs a registered read plus a compare/swap.
// Reset: count 0, capacity_limit 64; heap contents are never read unwritten.
// ----------------------------------------------------------------------------
module max_heap_priority_queue import mhpq_pkg::*; #(
  parameter int DEPTH         = 64,
  parameter int PRIORITY_BITS = 16,
  parameter int TAG_BITS      = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [APB_ADDR_BITS-1:0]         paddr,
  input  logic [APB_DATA_BITS-1:0]         pwdata,
  output logic [APB_DATA_BITS-1:0]         prdata,
  output logic                             pready,
  // request channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             action,
  input  logic signed [PRIORITY_BITS-1:0]  priority_req,
  input  logic [TAG_BITS-1:0]              tag,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       status,
  output logic signed [PRIORITY_BITS-1:0]  out_priority,
  output logic [TAG_BITS-1:0]              out_tag,
  output logic [FILL_BITS-1:0]             fill_level
);

  // Heap position p (0 = root) sits on level floor(log2(p+1)); one cell per
  // level, so LEVELS cells cover positions 0..DEPTH-1.
  localparam int LEVELS = $clog2(DEPTH + 1);
  localparam int LW     = $clog2(LEVELS);
  localparam int EW     = PRIORITY_BITS + TAG_BITS;
  localparam int CMPW   = (LEVELS > CAP_BITS) ? LEVELS : CAP_BITS;

  mhpq_state_t state, state_next;

  logic [CAP_BITS-1:0] capacity_limit;
  logic [LEVELS-1:0]   count;

  // sequencer outputs to the chain
  mhpq_tok_t         inj_ctl;
  logic [EW-1:0]     inj_ent;
  logic [LEVELS-1:0] path_al;
  logic [LW-1:0]     tgt_level;
  logic [LW-1:0]     fetch_lvl;
  logic              fetch_half;

  // pending result
  mhpq_status_t                    res_status;
  logic signed [PRIORITY_BITS-1:0] res_prio;
  logic [TAG_BITS-1:0]             res_tag;

  logic accept, cfg_we, full, empty, load_out;
  logic [CMPW-1:0] cap_eff;

  // walk descriptor: insert goes to position count, extract fetches count-1;
  // both are addressed through (position + 1)
  logic [LEVELS-1:0] walk_val, walk_al, last_idx;
  logic [LW-1:0]     walk_msb;
  logic [LEVELS-1:0] fetch_hit;

  // chain links
  mhpq_tok_t         tok_ctl_o [LEVELS];
  logic [LEVELS-1:0] tok_idx_o [LEVELS];
  logic [EW-1:0]     tok_ent_o [LEVELS];
  logic [LEVELS-1:0] wb_valid_o;
  logic [LEVELS-1:0] wb_idx_o  [LEVELS];
  logic [EW-1:0]     wb_ent_o  [LEVELS];
  logic [EW-1:0]     rd_l_all  [LEVELS];
  logic [EW-1:0]     rd_r_all  [LEVELS];
  logic [LEVELS-1:0] fin_all;
  logic [EW-1:0]     last_ent;

  // --------------------------------------------------------------------------
  // Configuration: a single register, capacity_limit, at byte address 0.
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_CAPACITY) ?
                  APB_DATA_BITS'(capacity_limit) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= CAP_RESET;
    end else if (cfg_we && (paddr[2] == REG_CAPACITY)) begin
      capacity_limit <= pwdata[CAP_BITS-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Request decode. A capacity above DEPTH acts as DEPTH; lowering it below
  // the count drops nothing, it only refuses inserts until extracts catch up.
  // --------------------------------------------------------------------------
  assign accept  = in_valid && in_ready;
  assign cap_eff = (CMPW'(capacity_limit) > CMPW'(DEPTH)) ? CMPW'(DEPTH)
                                                          : CMPW'(capacity_limit);
  assign full    = CMPW'(count) >= cap_eff;
  assign empty   = (count == '0);

  assign walk_val = (action == ACT_EXTRACT) ? count : (count + LEVELS'(1));

  // leading one of walk_val = heap level of the target position
  always_comb begin
    walk_msb = '0;
    for (int b = 0; b < LEVELS; b++) begin
      if (walk_val[b]) begin
        walk_msb = LW'(b);
      end
    end
  end

  // Left-align the path so that the branch taken into level m sits at bit
  // LEVELS-1-m for every cell; the index within the level drops the leading one.
  assign walk_al  = walk_val << (LW'(LEVELS - 1) - walk_msb);
  assign last_idx = walk_val ^ (LEVELS'(1) << walk_msb);

  // On an extract, root and last entry are read at the accept edge itself.
  always_comb begin
    for (int k = 0; k < LEVELS; k++) begin
      fetch_hit[k] = accept && (action == ACT_EXTRACT) && !empty &&
                     ((walk_msb == LW'(k)) || (k == 0));
    end
  end

  assign last_ent = fetch_half ? rd_r_all[fetch_lvl] : rd_l_all[fetch_lvl];

  // --------------------------------------------------------------------------
  // Sequencer
  //   IDLE  : take a word; refused/empty go straight to DONE
  //   FETCH : root and last entry are back; launch the sift-down at level 1 unless the heap is now empty
  //   BUSY  : token walks the chain until a cell reports finish
  //   DONE  : hand the result to the output register once it is free
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (action == ACT_INSERT) begin
            state_next = full ? ST_DONE : ST_BUSY;
          end else begin
            state_next = empty ? ST_DONE : ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        state_next = (count == '0) ? ST_DONE : ST_BUSY;
      end
      ST_BUSY: begin
        if (|fin_all) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == ST_IDLE);
    load_out = (state == ST_DONE) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (accept && (action == ACT_INSERT) && !full) begin
        count <= count + LEVELS'(1);
      end else if (accept && (action == ACT_EXTRACT) && !empty) begin
        count <= count - LEVELS'(1);
      end
    end
  end

  // token injection: inserts enter at the root cell, sift-downs at level 1
  always_ff @(posedge clk) begin
    if (rst) begin
      inj_ctl <= '0;
    end else begin
      inj_ctl <= '0;
      if (accept && (action == ACT_INSERT) && !full) begin
        inj_ctl <= '{active: 1'b1, extract: 1'b0, shifting: 1'b0};
      end else if ((state == ST_FETCH) && (count != '0)) begin
        inj_ctl <= '{active: 1'b1, extract: 1'b1, shifting: 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      inj_ent    <= {priority_req, tag};
      path_al    <= walk_al;
      tgt_level  <= walk_msb;
      fetch_lvl  <= walk_msb;
      fetch_half <= last_idx[0];
      res_prio   <= '0;
      res_tag    <= '0;
      if (action == ACT_INSERT) begin
        res_status <= full ? STATUS_FULL : STATUS_DONE;
      end else begin
        res_status <= empty ? STATUS_EMPTY : STATUS_DONE;
      end
    end else if (state == ST_FETCH) begin
      // last entry moves to the root and sinks from there
      inj_ent  <= last_ent;
      res_prio <= rd_l_all[0][EW-1:TAG_BITS];
      res_tag  <= rd_l_all[0][TAG_BITS-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      status       <= res_status;
      out_priority <= res_prio;
      out_tag      <= res_tag;
      fill_level   <= FILL_BITS'(count);
    end
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Chain of level cells. Tokens move down, registered on entry to and exit from each cell;
  // sift-down swaps send the winning child back up to the level above.
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < LEVELS; k++) begin : g_level
    mhpq_tok_t         tin_ctl;
    logic [LEVELS-1:0] tin_idx;
    logic [EW-1:0]     tin_ent;
    logic              win_valid;
    logic [LEVELS-1:0] win_idx;
    logic [EW-1:0]     win_ent;

    if (k == 0) begin : g_root_in
      assign tin_ctl = inj_ctl.extract ? '0 : inj_ctl;
      assign tin_idx = '0;
      assign tin_ent = inj_ent;
    end else if (k == 1) begin : g_first_in
      assign tin_ctl = inj_ctl.extract ? inj_ctl : tok_ctl_o[0];
      assign tin_idx = inj_ctl.extract ? '0 : tok_idx_o[0];
      assign tin_ent = inj_ctl.extract ? inj_ent : tok_ent_o[0];
    end else begin : g_chain_in
      assign tin_ctl = tok_ctl_o[k-1];
      assign tin_idx = tok_idx_o[k-1];
      assign tin_ent = tok_ent_o[k-1];
    end

    if (k == LEVELS - 1) begin : g_leaf_wb
      assign win_valid = 1'b0;
      assign win_idx   = '0;
      assign win_ent   = '0;
    end else begin : g_chain_wb
      assign win_valid = wb_valid_o[k+1];
      assign win_idx   = wb_idx_o[k+1];
      assign win_ent   = wb_ent_o[k+1];
    end

    mhpq_cell #(
      .LEVEL         (k),
      .LEVELS        (LEVELS),
      .DEPTH         (DEPTH),
      .PRIORITY_BITS (PRIORITY_BITS),
      .TAG_BITS      (TAG_BITS)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .tok_in_ctl   (tin_ctl),
      .tok_in_idx   (tin_idx),
      .tok_in_ent   (tin_ent),
      .tok_out_ctl  (tok_ctl_o[k]),
      .tok_out_idx  (tok_idx_o[k]),
      .tok_out_ent  (tok_ent_o[k]),
      .wb_in_valid  (win_valid),
      .wb_in_idx    (win_idx),
      .wb_in_ent    (win_ent),
      .wb_out_valid (wb_valid_o[k]),
      .wb_out_idx   (wb_idx_o[k]),
      .wb_out_ent   (wb_ent_o[k]),
      .fetch_hit    (fetch_hit[k]),
      .fetch_idx    ((k == 0) ? '0 : last_idx),
      .rd_left      (rd_l_all[k]),
      .rd_right     (rd_r_all[k]),
      .path_al      (path_al),
      .tgt_level    (tgt_level),
      .fill_count   (count),
      .fin          (fin_all[k])
    );
  end

endmodule

/* hw/rtl/mhpq_cell.sv */
// ----------------------------------------------------------------------------
// mhpq_cell
// One heap level. Holds the level's nodes as left/right child pairs indexed
// by parent, reads one pair per visit and performs one compare/swap step.
// ----------------------------------------------------------------------------
module mhpq_cell import mhpq_pkg::*; #(
  parameter int LEVEL         = 0,
  parameter int LEVELS        = 7,
  parameter int DEPTH         = 64,
  parameter int PRIORITY_BITS = 16,
  parameter int TAG_BITS      = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // token from the level above
  input  mhpq_tok_t                           tok_in_ctl,
  input  logic [LEVELS-1:0]                   tok_in_idx,
  input  logic [PRIORITY_BITS+TAG_BITS-1:0]   tok_in_ent,
  // token to the level below
  output mhpq_tok_t                           tok_out_ctl,
  output logic [LEVELS-1:0]                   tok_out_idx,
  output logic [PRIORITY_BITS+TAG_BITS-1:0]   tok_out_ent,
  // write-back from the level below
  input  logic                                wb_in_valid,
  input  logic [LEVELS-1:0]                   wb_in_idx,
  input  logic [PRIORITY_BITS+TAG_BITS-1:0]   wb_in_ent,
  // write-back to the level above
  output logic                                wb_out_valid,
  output logic [LEVELS-1:0]                   wb_out_idx,
  output logic [PRIORITY_BITS+TAG_BITS-1:0]   wb_out_ent,
  // direct read for root / last entry
  input  logic                                fetch_hit,
  input  logic [LEVELS-1:0]                   fetch_idx,
  output logic [PRIORITY_BITS+TAG_BITS-1:0]   rd_left,
  output logic [PRIORITY_BITS+TAG_BITS-1:0]   rd_right,
  // broadcast from the sequencer
  input  logic [LEVELS-1:0]                   path_al,
  input  logic [$clog2(LEVELS)-1:0]           tgt_level,
  input  logic [LEVELS-1:0]                   fill_count,
  output logic                                fin
);

  localparam int EW        = PRIORITY_BITS + TAG_BITS;
  localparam int LW        = $clog2(LEVELS);
  localparam int FIRST     = (1 << LEVEL) - 1;
  localparam int NODES     = ((1 << LEVEL) < (DEPTH - FIRST)) ? (1 << LEVEL) : (DEPTH - FIRST);
  localparam int WORDS     = (NODES + 1) / 2;
  localparam int WIW       = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PW        = LEVELS + 2;
  localparam int DIR_BIT   = (LEVEL == 0) ? 0 : (LEVELS - 1 - LEVEL);
  localparam bit LAST_LVL  = (LEVEL == LEVELS - 1);
  localparam logic [PW-1:0] FIRST_POS = PW'(FIRST);
  localparam logic [LW-1:0] MY_LEVEL  = LW'(LEVEL);

  logic [EW-1:0] bank_l [WORDS];
  logic [EW-1:0] bank_r [WORDS];

  mhpq_tok_t         tok_q;
  logic [LEVELS-1:0] idx_q;
  logic [EW-1:0]     ent_q;

  logic [WIW-1:0] rd_addr;
  logic           rd_en;

  logic signed [PRIORITY_BITS-1:0] c_prio, l_prio, r_prio, e_prio, win_prio;
  logic          dir, ins, ext, is_tgt, ins_swap;
  logic [PW-1:0] left_pos, right_pos;
  logic          lv, rv, take_l, take_r, moved;
  logic          own_we, own_half;

  mhpq_tok_t         tok_next;
  logic [LEVELS-1:0] idx_next;
  logic [EW-1:0]     ent_next;
  logic              wb_valid_next;
  logic [EW-1:0]     wb_ent_next;
  logic              fin_next;

  // read port: a visiting token or a direct fetch
  assign rd_addr = fetch_hit ? fetch_idx[WIW:1] : tok_in_idx[WIW-1:0];
  assign rd_en   = fetch_hit || tok_in_ctl.active;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_left  <= bank_l[rd_addr];
      rd_right <= bank_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    idx_q <= tok_in_idx;
    ent_q <= tok_in_ent;
    if (rst) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_in_ctl;
    end
  end

  always_comb begin
    c_prio   = ent_q[EW-1:TAG_BITS];
    l_prio   = rd_left[EW-1:TAG_BITS];
    r_prio   = rd_right[EW-1:TAG_BITS];
    dir      = (LEVEL == 0) ? 1'b0 : path_al[DIR_BIT];
    e_prio   = dir ? r_prio : l_prio;
    ins      = tok_q.active && !tok_q.extract;
    ext      = tok_q.active && tok_q.extract;
    is_tgt   = (tgt_level == MY_LEVEL);
    // once the new entry is placed, every lower path entry moves down one
    ins_swap = tok_q.shifting || (c_prio > e_prio);

    left_pos  = FIRST_POS + {1'b0, idx_q, 1'b0};
    right_pos = left_pos + PW'(1);
    lv        = left_pos  < PW'(fill_count);
    rv        = right_pos < PW'(fill_count);
    // left wins a tie between children; ties never swap
    take_l    = lv && (c_prio < l_prio);
    win_prio  = take_l ? l_prio : c_prio;
    take_r    = rv && (win_prio < r_prio);
    moved     = take_l || take_r;

    own_we    = (ins && (is_tgt || ins_swap)) || (ext && moved);
    own_half  = ins ? dir : take_r;

    tok_next.active   = (ins && !is_tgt) || (ext && moved && !LAST_LVL);
    tok_next.extract  = tok_q.extract;
    tok_next.shifting = ins && ins_swap;
    idx_next          = {idx_q[LEVELS-2:0], (ins ? dir : take_r)};
    ent_next          = (ins && ins_swap) ? (dir ? rd_right : rd_left) : ent_q;

    wb_valid_next = ext;
    wb_ent_next   = take_r ? rd_right : (take_l ? rd_left : ent_q);

    fin_next = (ins && is_tgt) || (ext && (!moved || LAST_LVL));
  end

  // write-back from below and own step never land in the same cycle
  always_ff @(posedge clk) begin
    if (wb_in_valid) begin
      if (wb_in_idx[0]) begin
        bank_r[wb_in_idx[WIW:1]] <= wb_in_ent;
      end else begin
        bank_l[wb_in_idx[WIW:1]] <= wb_in_ent;
      end
    end else if (own_we) begin
      if (own_half) begin
        bank_r[idx_q[WIW-1:0]] <= ent_q;
      end else begin
        bank_l[idx_q[WIW-1:0]] <= ent_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    tok_out_idx <= idx_next;
    tok_out_ent <= ent_next;
    wb_out_idx  <= idx_q;
    wb_out_ent  <= wb_ent_next;
    if (rst) begin
      tok_out_ctl  <= '0;
      wb_out_valid <= 1'b0;
      fin          <= 1'b0;
    end else begin
      tok_out_ctl  <= tok_next;
      wb_out_valid <= wb_valid_next;
      fin          <= fin_next;
    end
  end

endmodule

/* hw/rtl/mhpq_checker.sv */
// ----------------------------------------------------------------------------
// mhpq_checker
// Port-level checks for the max-heap priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module mhpq_checker import mhpq_pkg::*; #(
  parameter int PRIORITY_BITS = 16,
  parameter int TAG_BITS      = 16
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [1:0]                      status,
  input logic signed [PRIORITY_BITS-1:0] out_priority,
  input logic [TAG_BITS-1:0]             out_tag,
  input logic [FILL_BITS-1:0]            fill_level
);

  // one word in flight: taking a word closes the input side
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a word is in flight");

  // failed operations carry no entry
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != STATUS_DONE)) |-> ((out_priority == '0) && (out_tag == '0)))
    else $error("refused or empty result carries data");

  // an extract on empty reports an empty heap
  a_empty_fill: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == STATUS_EMPTY)) |-> (fill_level == '0))
    else $error("empty status with nonzero fill level");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(status) && $stable(out_tag) && $stable(fill_level)))
    else $error("stalled result changed");

endmodule

bind max_heap_priority_queue mhpq_checker #(
  .PRIORITY_BITS (PRIORITY_BITS),
  .TAG_BITS      (TAG_BITS)
) u_mhpq_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .out_priority (out_priority),
  .out_tag      (out_tag),
  .fill_level   (fill_level)
);

/* dv/mhpq_heap_monitor.sv */
// ----------------------------------------------------------------------------
// mhpq_heap_monitor
// Watches the request, result and register ports of the priority queue,
// keeps its own heap image and checks every result word field by field.
// ----------------------------------------------------------------------------
module mhpq_heap_monitor import mhpq_pkg::*; #(
  parameter int DEPTH         = 64,
  parameter int PRIORITY_BITS = 16,
  parameter int TAG_BITS      = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic                             pready,
  input  logic [APB_ADDR_BITS-1:0]         paddr,
  input  logic [APB_DATA_BITS-1:0]         pwdata,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic                             action,
  input  logic signed [PRIORITY_BITS-1:0]  priority_req,
  input  logic [TAG_BITS-1:0]              tag,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [1:0]                       status,
  input  logic signed [PRIORITY_BITS-1:0]  out_priority,
  input  logic [TAG_BITS-1:0]              out_tag,
  input  logic [FILL_BITS-1:0]             fill_level,
  output int                               mismatches,
  output int                               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [PRIORITY_BITS-1:0] pri;
    logic [TAG_BITS-1:0]             tg;
  } heap_slot_t;

  typedef struct {
    mhpq_status_t                    code;
    logic signed [PRIORITY_BITS-1:0] pri;
    logic [TAG_BITS-1:0]             tg;
    logic [FILL_BITS-1:0]            fill;
  } heap_result_t;

  heap_slot_t       slots [DEPTH];
  int               held;
  logic [CAP_BITS-1:0] cap_reg;
  heap_result_t     awaited_results [$];

  function automatic void swap_slots(int a, int b);
    heap_slot_t tmp;
    tmp      = slots[a];
    slots[a] = slots[b];
    slots[b] = tmp;
  endfunction

  // one request applied to the heap image; ties never move
  function automatic heap_result_t step_heap(logic op, logic signed [PRIORITY_BITS-1:0] pri,
                                             logic [TAG_BITS-1:0] tg);
    heap_result_t r;
    int lim, pos, up, lc, rc, best;
    r.code = STATUS_DONE;
    r.pri  = '0;
    r.tg   = '0;
    lim = (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
    if (op == ACT_INSERT) begin
      if (held >= lim) begin
        r.code = STATUS_FULL;
      end else begin
        pos = held;
        slots[pos].pri = pri;
        slots[pos].tg  = tg;
        held++;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (slots[up].pri < slots[pos].pri) begin
            swap_slots(up, pos);
            pos = up;
          end else begin
            break;
          end
        end
      end
    end else if (held == 0) begin
      r.code = STATUS_EMPTY;
    end else begin
      r.pri = slots[0].pri;
      r.tg  = slots[0].tg;
      held--;
      slots[0] = slots[held];
      pos = 0;
      forever begin
        lc   = 2 * pos + 1;
        rc   = 2 * pos + 2;
        best = pos;
        // left child wins a tie between children
        if (lc < held && slots[best].pri < slots[lc].pri) best = lc;
        if (rc < held && slots[best].pri < slots[rc].pri) best = rc;
        if (best == pos) break;
        swap_slots(pos, best);
        pos = best;
      end
    end
    r.fill = FILL_BITS'(held);
    return r;
  endfunction

  always @(posedge clk) begin
    heap_result_t want;
    if (rst) begin
      held    = 0;
      cap_reg = CAP_RESET;
      awaited_results.delete();
    end else begin
      // results first, so a word taken this edge is not matched against itself
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result word with none expected: status %0d prio %0d tag %0h fill %0d",
                   $time, status, out_priority, out_tag, fill_level);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (status !== want.code) begin
            $display("%0t: status expected %0d actual %0d", $time, want.code, status);
            mismatches++;
          end
          if (out_priority !== want.pri) begin
            $display("%0t: out_priority expected %0d actual %0d", $time, want.pri,
                     out_priority);
            mismatches++;
          end
          if (out_tag !== want.tg) begin
            $display("%0t: out_tag expected %0h actual %0h", $time, want.tg, out_tag);
            mismatches++;
          end
          if (fill_level !== want.fill) begin
            $display("%0t: fill_level expected %0d actual %0d", $time, want.fill, fill_level);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready)
        awaited_results.push_back(step_heap(action, priority_req, tag));
      if (psel && penable && pwrite && pready && paddr[APB_ADDR_BITS-1:2] == REG_CAPACITY)
        cap_reg = pwdata[CAP_BITS-1:0];
    end
    outstanding = awaited_results.size();
  end

endmodule

/* dv/tb_max_heap_priority_queue.sv */
// ----------------------------------------------------------------------------
// tb_max_heap_priority_queue
// Drives insert/extract words and capacity writes into the heap queue under
// random sender gaps and receiver stalls; the heap monitor predicts and checks
// every result word and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_max_heap_priority_queue import mhpq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH           = 64;
  localparam int PRIORITY_BITS   = 16;
  localparam int TAG_BITS        = 16;
  localparam int PHASES          = 10;
  localparam int WORDS_PER_PHASE = 153;
  // let the deepest sift finish; leave margin before touching the register
  localparam int SETTLE_CYCLES   = 24;
  localparam int CYCLE_LIMIT     = 400_000;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0]        paddr = '0;
  logic [APB_DATA_BITS-1:0]        pwdata = '0;
  logic [APB_DATA_BITS-1:0]        prdata;
  logic                            pready;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic                            action = ACT_INSERT;
  logic signed [PRIORITY_BITS-1:0] priority_req = '0;
  logic [TAG_BITS-1:0]             tag = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [1:0]                      status;
  logic signed [PRIORITY_BITS-1:0] out_priority;
  logic [TAG_BITS-1:0]             out_tag;
  logic [FILL_BITS-1:0]            fill_level;

  int          mismatches;
  int          outstanding;
  int unsigned cycle_count = 0;
  // when set, neither side inserts bubbles
  bit          steady = 1'b0;

  always #1 clk = ~clk;

  max_heap_priority_queue #(
    .DEPTH(DEPTH), .PRIORITY_BITS(PRIORITY_BITS), .TAG_BITS(TAG_BITS)
  ) dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_ready, .action, .priority_req, .tag,
    .out_valid, .out_ready, .status, .out_priority, .out_tag, .fill_level
  );

  mhpq_heap_monitor #(
    .DEPTH(DEPTH), .PRIORITY_BITS(PRIORITY_BITS), .TAG_BITS(TAG_BITS)
  ) heap_mon (
    .clk, .rst, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .in_valid, .in_ready, .action, .priority_req, .tag,
    .out_valid, .out_ready, .status, .out_priority, .out_tag, .fill_level,
    .mismatches, .outstanding
  );

  // watchdog: any hang ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side backpressure, ~1 stall in 3 unless in a steady stretch
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 33);
  end

  // One request word. Entered and left at a rising edge; valid stays up on
  // exit so back-to-back words never drop it inside one step.
  task automatic send_word(logic op, logic signed [PRIORITY_BITS-1:0] pri,
                           logic [TAG_BITS-1:0] tg);
    while (!steady && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    action       <= op;
    priority_req <= pri;
    tag          <= tg;
    do @(posedge clk); while (!in_ready);
  endtask

  // drain: sender holds off until every result is back, then lets the
  // sequencer go quiet before the next register write
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup then access; junk in the upper bits must be ignored
  task automatic write_capacity(logic [CAP_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CAPACITY, 2'b00};
    pwdata  <= ($urandom() & ~32'h7F) | APB_DATA_BITS'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    logic [CAP_BITS-1:0]             phase_cap [PHASES];
    int                              insert_pct [PHASES];
    logic signed [PRIORITY_BITS-1:0] pri;
    logic                            op;

    // lowered-below-count, zero, one, above-depth and full-depth settings
    phase_cap  = '{7'd127, 7'd3, 7'd64, 7'd1, 7'd0, 7'd20, 7'd64, 7'd65, 7'd2, 7'd64};
    insert_pct = '{85, 35, 75, 60, 25, 65, 80, 70, 40, 55};

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed: reset capacity (64) ---
    send_word(ACT_EXTRACT, 16'sd0, 16'h0000);      // extract from empty heap
    send_word(ACT_INSERT, 16'sh7FFF, 16'hFFFF);    // top priority, all-ones tag
    send_word(ACT_INSERT, -16'sd32768, 16'h0000);  // bottom priority
    send_word(ACT_INSERT, 16'sd0, 16'h1234);
    send_word(ACT_INSERT, -16'sd1, 16'h8000);
    send_word(ACT_INSERT, 16'sd0, 16'h0005);       // ties at zero
    send_word(ACT_INSERT, 16'sd0, 16'h0006);
    send_word(ACT_INSERT, 16'sh7FFF, 16'h0001);    // tie at the top
    repeat (8) send_word(ACT_EXTRACT, 16'sh7FFF, 16'hFFFF); // last one hits empty
    settle();

    // capacity of one: second insert refused
    write_capacity(7'd1);
    send_word(ACT_INSERT, 16'sd100, 16'hAAAA);
    send_word(ACT_INSERT, 16'sd200, 16'h5555);
    send_word(ACT_EXTRACT, 16'sd0, 16'h0000);
    send_word(ACT_EXTRACT, 16'sd0, 16'h0000);
    settle();

    // zero capacity refuses everything
    write_capacity(7'd0);
    send_word(ACT_INSERT, 16'sd1, 16'h0F0F);
    send_word(ACT_EXTRACT, 16'sd0, 16'h0000);
    settle();

    // --- random phases ---
    for (int ph = 0; ph < PHASES; ph++) begin
      write_capacity(phase_cap[ph]);
      steady = (ph == 6);
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        op = ($urandom_range(0, 99) < insert_pct[ph]) ? ACT_INSERT : ACT_EXTRACT;
        // narrow values often, to force ties during sifting
        case ($urandom_range(0, 9))
          0, 1, 2: pri = PRIORITY_BITS'($signed($urandom_range(0, 2)) - 1);
          3:       pri = $urandom_range(0, 1) ? 16'sh7FFF : -16'sd32768;
          default: pri = PRIORITY_BITS'($urandom());
        endcase
        send_word(op, pri, TAG_BITS'($urandom()));
      end
      settle();
    end
    steady = 1'b0;

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/mhpq_pkg.sv
hw/rtl/mhpq_cell.sv
hw/rtl/max_heap_priority_queue.sv
hw/rtl/mhpq_checker.sv
dv/mhpq_heap_monitor.sv
dv/tb_max_heap_priority_queue.sv
